// File: src/qsm_pkg.sv
package qsm_pkg;

  localparam int MAX_SAMPLES  = 16;
  localparam int SAMPLE_WIDTH = 32;
  localparam int IDX_W        = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [SAMPLE_WIDTH-1:0] sample_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_CHECK,
    S_MOT2,
    S_MOT3,
    S_MOT4,
    S_PIV_RD,
    S_PIV_CAP,
    S_LL_STEP,
    S_LL_TEST,
    S_HH_STEP,
    S_HH_TEST,
    S_NARROW,
    S_CAS_RD,
    S_CAS_CMP,
    S_CAS_WR,
    S_FETCH,
    S_DONE
  } state_t;

endpackage

// File: src/qsm_if.sv
interface qsm_in_if import qsm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_value;
  logic    last_sample;

  modport source (output valid, output sample_value, output last_sample, input ready);
  modport sink (input valid, input sample_value, input last_sample, output ready);
endinterface

interface qsm_out_if import qsm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t median_value;
  logic    overflow;

  modport source (output valid, output median_value, output overflow, input ready);
  modport sink (input valid, input median_value, input overflow, output ready);
endinterface

// File: src/quickselect_median.sv
// channel   dir   beat payload                     notes
// samples   in    sample_value, last_sample        last_sample closes the set
// result    out   median_value, overflow           one beat per closed set
//
// Each valid sample beat is taken while loading; samples is ready only while loading.
// After the last beat a sequencer runs quickselect on one shared comparator and a
// store with two registered read ports and one write port. A scan step reads
// and then tests; a compare-exchange reads, compares and, on a swap, writes both
// entries in turn; a fetch reads the median entry and then hands it off.
// rst (synchronous) empties the set and drops a pending result; the store is not cleared.
// A held result stalls the handoff of the next one; loading of a new set waits meanwhile.
module quickselect_median import qsm_pkg::*; (
  input logic   clk,
  input logic   rst,
  qsm_in_if.sink    samples,
  qsm_out_if.source result
);

  sample_t store [MAX_SAMPLES];
  sample_t rd0, rd1;

  state_t  state, state_next, ret, ret_next;
  cnt_t    count, count_next;
  logic    ovf_seen, ovf_next;
  idx_t    low, low_next, high, high_next, med, med_next, mid, mid_next;
  idx_t    ll, ll_next, hh, hh_next, ci, ci_next, cj, cj_next;
  logic    must_swap, must_swap_next;
  sample_t pivot, pivot_next;
  logic    res_valid, res_valid_next, res_ovf, res_ovf_next;
  sample_t res_value, res_value_next;

  logic    we, re;
  idx_t    wa, ra0, ra1;
  sample_t wd, cmp_a, cmp_b;
  logic    gt;

  logic [IDX_W:0] range_sum;
  logic [IDX_W:0] low_inc;
  idx_t           last_high;

  assign samples.ready       = (state == S_LOAD);
  assign result.valid        = res_valid;
  assign result.median_value = res_value;
  assign result.overflow     = res_ovf;

  assign range_sum = {1'b0, low} + {1'b0, high};
  assign low_inc   = {1'b0, low} + 1'b1;
  assign last_high = (count < cnt_t'(MAX_SAMPLES)) ? count[IDX_W-1:0] : idx_t'(MAX_SAMPLES - 1);

  // shared comparator
  always_comb begin
    case (state)
      S_LL_TEST: begin
        cmp_a = pivot;
        cmp_b = rd0;
      end
      S_HH_TEST: begin
        cmp_a = rd0;
        cmp_b = pivot;
      end
      default: begin
        cmp_a = rd0;
        cmp_b = rd1;
      end
    endcase
  end

  assign gt = cmp_a > cmp_b;

  always_comb begin
    state_next     = state;
    ret_next       = ret;
    count_next     = count;
    ovf_next       = ovf_seen;
    low_next       = low;
    high_next      = high;
    med_next       = med;
    mid_next       = mid;
    ll_next        = ll;
    hh_next        = hh;
    ci_next        = ci;
    cj_next        = cj;
    must_swap_next = must_swap;
    pivot_next     = pivot;
    res_valid_next = res_valid && !result.ready;
    res_value_next = res_value;
    res_ovf_next   = res_ovf;
    we             = 1'b0;
    wa             = ci;
    wd             = rd1;
    re             = 1'b0;
    ra0            = ci;
    ra1            = cj;

    case (state)
      S_LOAD: begin
        if (samples.valid) begin
          if (count < cnt_t'(MAX_SAMPLES)) begin
            we         = 1'b1;
            wa         = count[IDX_W-1:0];
            wd         = samples.sample_value;
            count_next = cnt_t'(count + 1'b1);
          end else begin
            ovf_next = 1'b1;
          end
          if (samples.last_sample) begin
            low_next   = '0;
            high_next  = last_high;
            med_next   = last_high >> 1;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (high <= low) begin
          state_next = S_FETCH;
        end else if ({1'b0, high} == low_inc) begin
          ci_next        = low;
          cj_next        = high;
          must_swap_next = 1'b0;
          ret_next       = S_FETCH;
          state_next     = S_CAS_RD;
        end else begin
          mid_next       = range_sum[IDX_W:1];
          ci_next        = range_sum[IDX_W:1];
          cj_next        = high;
          must_swap_next = 1'b0;
          ret_next       = S_MOT2;
          state_next     = S_CAS_RD;
        end
      end
      S_MOT2: begin
        ci_next    = low;
        cj_next    = high;
        ret_next   = S_MOT3;
        state_next = S_CAS_RD;
      end
      S_MOT3: begin
        ci_next    = mid;
        cj_next    = low;
        ret_next   = S_MOT4;
        state_next = S_CAS_RD;
      end
      S_MOT4: begin
        ci_next        = mid;
        cj_next        = low_inc[IDX_W-1:0];
        must_swap_next = 1'b1;
        ret_next       = S_PIV_RD;
        state_next     = S_CAS_RD;
      end
      S_PIV_RD: begin
        re         = 1'b1;
        ra0        = low;
        state_next = S_PIV_CAP;
      end
      S_PIV_CAP: begin
        pivot_next = rd0;
        ll_next    = low_inc[IDX_W-1:0];
        hh_next    = high;
        state_next = S_LL_STEP;
      end
      S_LL_STEP: begin
        ll_next    = idx_t'(ll + 1'b1);
        re         = 1'b1;
        ra0        = idx_t'(ll + 1'b1);
        state_next = S_LL_TEST;
      end
      S_LL_TEST: begin
        if (ll < high && gt) begin
          state_next = S_LL_STEP;
        end else begin
          state_next = S_HH_STEP;
        end
      end
      S_HH_STEP: begin
        hh_next    = idx_t'(hh - 1'b1);
        re         = 1'b1;
        ra0        = idx_t'(hh - 1'b1);
        state_next = S_HH_TEST;
      end
      S_HH_TEST: begin
        if ({1'b0, hh} > low_inc && gt) begin
          state_next = S_HH_STEP;
        end else if (hh < ll) begin
          ci_next        = low;
          cj_next        = hh;
          must_swap_next = 1'b1;
          ret_next       = S_NARROW;
          state_next     = S_CAS_RD;
        end else begin
          ci_next        = ll;
          cj_next        = hh;
          must_swap_next = 1'b1;
          ret_next       = S_LL_STEP;
          state_next     = S_CAS_RD;
        end
      end
      S_NARROW: begin
        if (hh <= med) begin
          low_next = ll;
        end
        if (hh >= med) begin
          high_next = idx_t'(hh - 1'b1);
        end
        state_next = S_CHECK;
      end
      S_CAS_RD: begin
        re         = 1'b1;
        state_next = S_CAS_CMP;
      end
      S_CAS_CMP: begin
        if (must_swap || gt) begin
          we         = 1'b1;
          wa         = ci;
          wd         = rd1;
          state_next = S_CAS_WR;
        end else begin
          state_next = ret;
        end
      end
      S_CAS_WR: begin
        we         = 1'b1;
        wa         = cj;
        wd         = rd0;
        state_next = ret;
      end
      S_FETCH: begin
        re         = 1'b1;
        ra0        = med;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!res_valid || result.ready) begin
          res_valid_next = 1'b1;
          res_value_next = rd0;
          res_ovf_next   = ovf_seen;
          count_next     = '0;
          ovf_next       = 1'b0;
          state_next     = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf_seen  <= 1'b0;
      res_valid <= 1'b0;
      low       <= '0;
      high      <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf_seen  <= ovf_next;
      res_valid <= res_valid_next;
      low       <= low_next;
      high      <= high_next;
    end
  end

  always_ff @(posedge clk) begin
    ret       <= ret_next;
    med       <= med_next;
    mid       <= mid_next;
    ll        <= ll_next;
    hh        <= hh_next;
    ci        <= ci_next;
    cj        <= cj_next;
    must_swap <= must_swap_next;
    pivot     <= pivot_next;
    res_value <= res_value_next;
    res_ovf   <= res_ovf_next;
  end

  // sample store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      store[wa] <= wd;
    end
    if (re) begin
      rd0 <= store[ra0];
      rd1 <= store[ra1];
    end
  end

endmodule

// File: src/qsm_checker.sv
module qsm_checker import qsm_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    samples_valid,
  input logic    samples_ready,
  input logic    last_sample,
  input logic    result_valid,
  input logic    result_ready,
  input sample_t median_value,
  input logic    overflow
);

  // closing beat starts selection: no further beats taken next cycle
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    samples_valid && samples_ready && last_sample |=> !samples_ready)
    else $error("samples ready right after closing beat");

  // results come only from the selection phase
  a_result_from_select: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!samples_ready))
    else $error("result raised while loading");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(median_value) && $stable(overflow))
    else $error("result beat dropped or changed under stall");

  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> !result_valid && samples_ready)
    else $error("block not idle after reset");

endmodule

bind quickselect_median qsm_checker u_qsm_checker (
  .clk           (clk),
  .rst           (rst),
  .samples_valid (samples.valid),
  .samples_ready (samples.ready),
  .last_sample   (samples.last_sample),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .median_value  (result.median_value),
  .overflow      (result.overflow)
);
